// ===== design/sicrt_pkg.sv =====
// ---------------------------------------------------------------------------
// sicrt_pkg
// Shared types and constants for the signed integer to radix text block.
// ---------------------------------------------------------------------------
package sicrt_pkg;

   localparam int unsigned BASE_MAX    = 16;
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned SIZE_W      = 5;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned COUNT_W     = 6;
   localparam int unsigned STACK_W     = VALUE_W * DIGIT_W;
   localparam int unsigned STEPS_PER_CYCLE = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_SIZE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
   localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
   localparam logic [SIZE_W-1:0] BASE_MIN   = 5'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_step;
      logic push;
      logic emit_minus;
      logic emit_digit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic alpha_ok;
      logic negative;
      logic quot_zero;
      logic count_full;
      logic count_one;
   } status_type;

endpackage

// ===== design/sicrt_req_if.sv =====
// ---------------------------------------------------------------------------
// sicrt_req_if
// Input channel: one signed value per beat.
// ---------------------------------------------------------------------------
interface sicrt_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// ===== design/sicrt_rsp_if.sv =====
// ---------------------------------------------------------------------------
// sicrt_rsp_if
// Result channel: one text character per beat, with an end-of-text flag.
// ---------------------------------------------------------------------------
interface sicrt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== design/sicrt_ctrl.sv =====
// ---------------------------------------------------------------------------
// sicrt_ctrl
// Sequencer: checks the alphabet, runs the digit divisions, then streams the
// sign and the digits out through the result register.
// ---------------------------------------------------------------------------
module sicrt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   input  sicrt_pkg::status_type status,
   output sicrt_pkg::cmd_type    cmd
);
   import sicrt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_PUSH,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   state_type  state_ff;
   logic [1:0] step_ff;
   logic       rsp_valid_ff;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.load       = (state_ff == ST_IDLE) && req_valid;
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.push       = (state_ff == ST_PUSH);
      cmd.emit_minus = (state_ff == ST_SIGN) && status.negative && slot_free;
      cmd.emit_digit = (state_ff == ST_DIGIT) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit_minus || cmd.emit_digit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               step_ff  <= '0;
               state_ff <= status.alpha_ok ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd3) begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               step_ff  <= '0;
               state_ff <= (status.quot_zero || status.count_full) ? ST_SIGN : ST_DIV;
            end
            ST_SIGN: begin
               if (!status.negative || slot_free) begin
                  state_ff <= ST_DIGIT;
               end
            end
            ST_DIGIT: begin
               if (slot_free && status.count_one) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/sicrt_dp.sv =====
// ---------------------------------------------------------------------------
// sicrt_dp
// Datapath: configuration registers, alphabet check, shift-subtract divider,
// digit stack and result register.
// ---------------------------------------------------------------------------
module sicrt_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [sicrt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sicrt_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic signed [sicrt_pkg::VALUE_W-1:0] value,
   input  sicrt_pkg::cmd_type                   cmd,
   output sicrt_pkg::status_type                status,
   output logic [sicrt_pkg::CHAR_W-1:0]         character,
   output logic                                 last
);
   import sicrt_pkg::*;

   logic [SIZE_W-1:0]       base_size_ff;
   logic [CSR_DATA_W-1:0]   symbols_low_ff;
   logic [CSR_DATA_W-1:0]   symbols_high_ff;
   logic                    alpha_ok_ff;
   logic                    alpha_ok_in;
   logic [2*CSR_DATA_W-1:0] symbols;

   logic [VALUE_W-1:0]      mag_ff;
   logic [VALUE_W-1:0]      mag_in;
   logic [SIZE_W-1:0]       rem_ff;
   logic [SIZE_W-1:0]       rem_in;
   logic                    neg_ff;
   logic [COUNT_W-1:0]      count_ff;
   logic [STACK_W-1:0]      stack_ff;
   logic [CHAR_W-1:0]       char_ff;
   logic                    last_ff;
   logic [VALUE_W-1:0]      raw;

   assign symbols = {symbols_high_ff, symbols_low_ff};
   assign raw     = value;

   // Alphabet check: base_size is 2 to 16, every symbol in use is nonzero, not
   // a sign character and unlike every other symbol in use.
   always_comb begin
      logic [CHAR_W-1:0] si;
      logic [CHAR_W-1:0] sj;
      alpha_ok_in = (base_size_ff >= BASE_MIN) && (base_size_ff <= SIZE_W'(BASE_MAX));
      for (int i = 0; i < BASE_MAX; i++) begin
         si = symbols[i*CHAR_W +: CHAR_W];
         if ((SIZE_W'(i) < base_size_ff) &&
             ((si == '0) || (si == MINUS_CHAR) || (si == PLUS_CHAR))) begin
            alpha_ok_in = 1'b0;
         end
         for (int j = i + 1; j < BASE_MAX; j++) begin
            sj = symbols[j*CHAR_W +: CHAR_W];
            if ((SIZE_W'(j) < base_size_ff) && (si == sj)) begin
               alpha_ok_in = 1'b0;
            end
         end
      end
   end

   // Eight restoring division steps per cycle; the quotient shifts into the
   // magnitude register as its dividend bits shift out.
   always_comb begin
      logic [SIZE_W-1:0]  r;
      logic [VALUE_W-1:0] m;
      r = rem_ff;
      m = mag_ff;
      for (int s = 0; s < STEPS_PER_CYCLE; s++) begin
         r = {r[SIZE_W-2:0], m[VALUE_W-1]};
         m = {m[VALUE_W-2:0], 1'b0};
         if (r >= base_size_ff) begin
            r    = r - base_size_ff;
            m[0] = 1'b1;
         end
      end
      rem_in = r;
      mag_in = m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_size_ff    <= '0;
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
         alpha_ok_ff     <= 1'b0;
      end else begin
         alpha_ok_ff <= alpha_ok_in;
         if (csr_write) begin
            case (csr_index)
               CSR_BASE_SIZE:    base_size_ff    <= csr_data[SIZE_W-1:0];
               CSR_SYMBOLS_LOW:  symbols_low_ff  <= csr_data;
               CSR_SYMBOLS_HIGH: symbols_high_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff   <= raw[VALUE_W-1];
         mag_ff   <= raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
         rem_ff   <= '0;
         count_ff <= '0;
      end
      if (cmd.div_step) begin
         mag_ff <= mag_in;
         rem_ff <= rem_in;
      end
      if (cmd.push) begin
         stack_ff <= {stack_ff[STACK_W-DIGIT_W-1:0], rem_ff[DIGIT_W-1:0]};
         count_ff <= count_ff + COUNT_W'(1);
         rem_ff   <= '0;
      end
      if (cmd.emit_minus) begin
         char_ff <= MINUS_CHAR;
         last_ff <= 1'b0;
      end
      if (cmd.emit_digit) begin
         char_ff  <= symbols[stack_ff[DIGIT_W-1:0]*CHAR_W +: CHAR_W];
         last_ff  <= (count_ff == COUNT_W'(1));
         stack_ff <= {{DIGIT_W{1'b0}}, stack_ff[STACK_W-1:DIGIT_W]};
         count_ff <= count_ff - COUNT_W'(1);
      end
   end

   always_comb begin
      status.alpha_ok   = alpha_ok_ff;
      status.negative   = neg_ff;
      status.quot_zero  = (mag_ff == '0);
      status.count_full = (count_ff == COUNT_W'(VALUE_W - 1));
      status.count_one  = (count_ff == COUNT_W'(1));
   end

   assign character = char_ff;
   assign last      = last_ff;

endmodule

// ===== design/signed_int_to_custom_radix_text.sv =====
// ---------------------------------------------------------------------------
// signed_int_to_custom_radix_text
// Writes a signed 32-bit value as text in a configurable radix.
// ---------------------------------------------------------------------------
// Each request beat carries one signed value; the block answers with one
// response beat per character: a minus sign for negative values, then the
// digits of the magnitude, most significant first, with last set on the
// final digit. The most negative value prints its true magnitude. The radix
// and its digit alphabet come from three registers: base_size (index 0), the
// number of symbols, and symbols_low / symbols_high (indexes 1 and 2), which
// hold symbols 0 to 7 and 8 to 15, one byte each, symbol 0 in the lowest
// byte. The alphabet is usable when base_size is 2 to 16 and the symbols in
// use are nonzero, pairwise distinct and neither plus nor minus; otherwise a
// request is consumed and produces no response at all, and the block is
// ready again once the alphabet check is done. Write the registers only while no
// request is in flight. A request is taken only when the block is idle.
// After it, the alphabet is checked, then each digit takes one full division
// by the shared shift-subtract divider, which retires eight quotient bits
// per cycle, and a push of the remainder onto the digit stack. The sign is
// handled next, whether or not a minus goes out, and the digits leave at
// one per cycle while the sink is ready. The sign and digit states wait
// while the sink holds off a waiting character. The result register lets
// the next request start while the last character still waits for the
// sink.
// ---------------------------------------------------------------------------
module signed_int_to_custom_radix_text (
   input  logic                              clock,
   input  logic                              reset,
   sicrt_req_if.sink                         req_chan,
   sicrt_rsp_if.source                       rsp_chan,
   input  logic                              csr_write,
   input  logic [sicrt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sicrt_pkg::CSR_DATA_W-1:0]  csr_data
);
   import sicrt_pkg::*;

   // Command and status bundles between the sequencer and the datapath.
   cmd_type    cmd;
   status_type status;

   // The sequencer owns the handshakes; the datapath owns every payload bit.
   sicrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   sicrt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .value     (req_chan.value),
      .cmd       (cmd),
      .status    (status),
      .character (rsp_chan.character),
      .last      (rsp_chan.last)
   );

endmodule
